/* hdl/cvk_pkg.sv */
// Shared types, constants and round functions for the keystream block generator.
// Used by every module of the block; depends on nothing.
package cvk_pkg;

    typedef logic [31:0] t_word;
    typedef logic [15:0][31:0] t_state;

    // Configuration register indexes (paddr[5:3]).
    localparam logic [2:0] REG_KEY_01   = 3'd0;
    localparam logic [2:0] REG_KEY_23   = 3'd1;
    localparam logic [2:0] REG_KEY_45   = 3'd2;
    localparam logic [2:0] REG_KEY_67   = 3'd3;
    localparam logic [2:0] REG_NONCE_01 = 3'd4;
    localparam logic [2:0] REG_NONCE_2  = 3'd5;

    localparam t_word CONST_0 = 32'h6F6C6C76;
    localparam t_word CONST_1 = 32'h6D2D6B65;
    localparam t_word CONST_2 = 32'h79323178;
    localparam t_word CONST_3 = 32'h21212121;

    localparam int ROT_A = 13;
    localparam int ROT_B = 9;
    localparam int ROT_C = 5;
    localparam int ROT_D = 11;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
    } t_cfg;

    // Head of the input queue as seen by the round engine.
    typedef struct packed {
        logic  valid;
        t_word counter;
    } t_qhead;

    // Finished block handed from the round engine to the output stage.
    typedef struct packed {
        logic   load;
        t_state words;
    } t_block;

    function automatic t_word rotl(input t_word v, input int n);
        t_word r;
        r = (v << n) | (v >> (32 - n));
        return r;
    endfunction

    function automatic logic [3:0][31:0] qround(input t_word a, input t_word b,
                                                input t_word c, input t_word d);
        t_word ta;
        t_word tb;
        t_word tc;
        t_word td;
        ta = a;
        tb = b;
        tc = c;
        td = d;
        ta = ta + tb; td = rotl(td ^ ta, ROT_A);
        tc = tc + td; tb = rotl(tb ^ tc, ROT_B);
        ta = ta + tb; td = rotl(td ^ ta, ROT_C);
        tc = tc + td; tb = rotl(tb ^ tc, ROT_D);
        return {td, tc, tb, ta};
    endfunction

    // One column round or one diagonal round: four independent quarter rounds.
    function automatic t_state half_round(input t_state s, input logic diag);
        t_state r;
        logic [3:0][31:0] q;
        r = s;
        if (!diag) begin
            for (int i = 0; i < 4; i++) begin
                q = qround(s[i], s[4 + i], s[8 + i], s[12 + i]);
                r[i]      = q[0];
                r[4 + i]  = q[1];
                r[8 + i]  = q[2];
                r[12 + i] = q[3];
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                q = qround(s[i], s[4 + ((i + 1) % 4)], s[8 + ((i + 2) % 4)],
                           s[12 + ((i + 3) % 4)]);
                r[i]                  = q[0];
                r[4 + ((i + 1) % 4)]  = q[1];
                r[8 + ((i + 2) % 4)]  = q[2];
                r[12 + ((i + 3) % 4)] = q[3];
            end
        end
        return r;
    endfunction

    function automatic t_state init_state(input t_cfg cfg, input t_word counter);
        t_state s;
        s[0] = CONST_0;
        s[1] = CONST_1;
        s[2] = CONST_2;
        s[3] = CONST_3;
        for (int i = 0; i < 8; i++) begin
            s[4 + i] = cfg.key[i];
        end
        s[12] = counter;
        s[13] = cfg.nonce[0];
        s[14] = cfg.nonce[1];
        s[15] = cfg.nonce[2];
        return s;
    endfunction

endpackage

/* hdl/chacha_variant_keystream_block.sv */
// Keystream block generator: a modified ChaCha block function.
// Top level; depends on cvk_pkg, cvk_regs, cvk_front, cvk_core and cvk_out.
//
// Usage:
//   Load the key and nonce words through the APB-style port while the block
//   is idle. Each 64-bit register sits at byte address 8*i.
//   Push a 32-bit block counter on the input queue (push/full). For each
//   item the result queue (empty/pop) yields sixteen 32-bit words, index 0
//   to 15, with the last one marked.
//   An item accepted by an idle block is loaded into the round engine, runs
//   its rounds and passes to the output buffer; its first word then shows on
//   the result ports, where it can be popped at once.
//   Throughput: the round engine does one column or diagonal round per
//   cycle while it runs; a finished block waits there until the output
//   buffer can take it. That engine sets the sustained rate. Emptying the
//   sixteen words overlaps the rounds of the next block.
//   A two-entry input queue and a one-block output buffer let each side stall
//   on its own; when the receiver stops popping, finished blocks wait and
//   full rises once the input queue fills.
//   Reset (synchronous, active low) empties both queues and clears the key
//   and nonce registers to zero.
module chacha_variant_keystream_block #(
    parameter int DOUBLE_ROUNDS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_block_counter,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_word_index,
    output logic [31:0] o_keystream_word,
    output logic        o_last_word
);

    cvk_pkg::t_cfg   cfg;
    cvk_pkg::t_qhead head;
    cvk_pkg::t_block block;
    logic            take;
    logic            out_ready;

    cvk_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cvk_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_block_counter (i_block_counter),
        .o_head          (head),
        .i_take          (take)
    );

    cvk_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_head      (head),
        .o_take      (take),
        .i_out_ready (out_ready),
        .o_block     (block)
    );

    cvk_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_block          (block),
        .o_ready          (out_ready),
        .empty            (empty),
        .pop              (pop),
        .o_word_index     (o_word_index),
        .o_keystream_word (o_keystream_word),
        .o_last_word      (o_last_word)
    );

endmodule

/* hdl/cvk_regs.sv */
// APB-style configuration register file holding the key and nonce words.
// Depends on cvk_pkg.
module cvk_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output cvk_pkg::t_cfg o_cfg
);

    logic [3:0][63:0] r_key;
    logic [63:0]      r_nonce_01;
    logic [31:0]      r_nonce_2;
    logic             wr_en;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_nonce_01 <= '0;
            r_nonce_2  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                cvk_pkg::REG_KEY_01:   r_key[0]   <= pwdata;
                cvk_pkg::REG_KEY_23:   r_key[1]   <= pwdata;
                cvk_pkg::REG_KEY_45:   r_key[2]   <= pwdata;
                cvk_pkg::REG_KEY_67:   r_key[3]   <= pwdata;
                cvk_pkg::REG_NONCE_01: r_nonce_01 <= pwdata;
                cvk_pkg::REG_NONCE_2:  r_nonce_2  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cvk_pkg::REG_KEY_01:   prdata = r_key[0];
            cvk_pkg::REG_KEY_23:   prdata = r_key[1];
            cvk_pkg::REG_KEY_45:   prdata = r_key[2];
            cvk_pkg::REG_KEY_67:   prdata = r_key[3];
            cvk_pkg::REG_NONCE_01: prdata = r_nonce_01;
            cvk_pkg::REG_NONCE_2:  prdata = {32'd0, r_nonce_2};
            default:               prdata = '0;
        endcase
    end

    // Each 64-bit key register carries the lower-numbered word in its low half.
    assign o_cfg.key   = r_key;
    assign o_cfg.nonce = {r_nonce_2, r_nonce_01[63:32], r_nonce_01[31:0]};

endmodule

/* hdl/cvk_front.sv */
// Input side: a two-entry queue of block counters in front of the round engine.
// Depends on cvk_pkg.
module cvk_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [31:0]     i_block_counter,
    output cvk_pkg::t_qhead o_head,
    input  logic            i_take
);

    logic [1:0][31:0] r_data;
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign full    = (r_count == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = i_take && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_block_counter;
        end
    end

    assign o_head.valid   = (r_count != 2'd0);
    assign o_head.counter = r_data[r_rptr];

endmodule

/* hdl/cvk_core.sv */
// Round engine: one column or diagonal round per cycle, then the feed-forward add.
// Depends on cvk_pkg.
module cvk_core #(
    parameter int DOUBLE_ROUNDS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cvk_pkg::t_cfg   i_cfg,
    input  cvk_pkg::t_qhead i_head,
    output logic            o_take,
    input  logic            i_out_ready,
    output cvk_pkg::t_block o_block
);

    localparam int RW = $clog2(2 * DOUBLE_ROUNDS);
    localparam logic [RW-1:0] LAST_ROUND = RW'(2 * DOUBLE_ROUNDS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_fsm;

    t_fsm             r_fsm;
    logic [RW-1:0]    r_round;
    cvk_pkg::t_state  r_state;
    cvk_pkg::t_word   r_counter;
    cvk_pkg::t_state  init_now;
    cvk_pkg::t_state  init_head;
    logic             hand_off;

    // The user must change the key and nonce only while the block is idle; the
    // block does not enforce it. The final add rebuilds init state from r_counter.
    assign init_now  = cvk_pkg::init_state(i_cfg, r_counter);
    assign init_head = cvk_pkg::init_state(i_cfg, i_head.counter);
    assign hand_off  = (r_fsm == S_DONE) && i_out_ready;
    assign o_take    = i_head.valid && ((r_fsm == S_IDLE) || hand_off);

    always_comb begin
        o_block.load = hand_off;
        for (int i = 0; i < 16; i++) begin
            o_block.words[i] = r_state[i] + init_now[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_round <= '0;
        end else begin
            case (r_fsm)
                S_IDLE: begin
                    if (o_take) begin
                        r_fsm   <= S_RUN;
                        r_round <= '0;
                    end
                end
                S_RUN: begin
                    if (r_round == LAST_ROUND) begin
                        r_fsm <= S_DONE;
                    end else begin
                        r_round <= r_round + RW'(1);
                    end
                end
                S_DONE: begin
                    if (hand_off) begin
                        r_fsm   <= o_take ? S_RUN : S_IDLE;
                        r_round <= '0;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
        if (o_take) begin
            r_state   <= init_head;
            r_counter <= i_head.counter;
        end else if (r_fsm == S_RUN) begin
            r_state <= cvk_pkg::half_round(r_state, r_round[0]);
        end
    end

endmodule

/* hdl/cvk_out.sv */
// Output stage: holds one finished block and hands its sixteen words out in order.
// Depends on cvk_pkg.
module cvk_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cvk_pkg::t_block i_block,
    output logic            o_ready,
    output logic            empty,
    input  logic            pop,
    output logic [3:0]      o_word_index,
    output logic [31:0]     o_keystream_word,
    output logic            o_last_word
);

    cvk_pkg::t_state r_words;
    logic [4:0]      r_cnt;
    logic [3:0]      r_idx;
    logic            do_pop;

    assign empty   = (r_cnt == 5'd0);
    assign do_pop  = pop && !empty;
    // A new block may enter as the last word of the current one leaves.
    assign o_ready = empty || ((r_cnt == 5'd1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
            r_idx <= 4'd0;
        end else if (i_block.load) begin
            r_cnt <= 5'd16;
            r_idx <= 4'd0;
        end else if (do_pop) begin
            r_cnt <= r_cnt - 5'd1;
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_block.load) begin
            r_words <= i_block.words;
        end else if (do_pop) begin
            for (int i = 0; i < 15; i++) begin
                r_words[i] <= r_words[i + 1];
            end
        end
    end

    assign o_word_index     = r_idx;
    assign o_keystream_word = r_words[0];
    assign o_last_word      = (r_idx == 4'd15);

endmodule
